// File: src/assert_macros.svh
// Assertion helpers shared by the RTL. Clock and reset are taken from the
// enclosing module's ports.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define DRQ_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Same-cycle implication.
`define DRQ_ASSERT_IMPLY(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define DRQ_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/drqba_pkg.sv
package drqba_pkg;

   localparam int QUEUE_DEPTH_DEF = 16;
   localparam int ID_WIDTH_DEF    = 16;

   localparam logic [6:0] BURST_RESET = 7'd10;
   localparam logic [6:0] MAX_BURST   = 7'd64;

   // request function codes
   localparam logic [1:0] FUNC_ENQ_N = 2'd0;
   localparam logic [1:0] FUNC_ENQ_S = 2'd1;
   localparam logic [1:0] FUNC_TURN  = 2'd2;

   // result kinds
   localparam logic [1:0] KIND_ACCEPT  = 2'd0;
   localparam logic [1:0] KIND_REJECT  = 2'd1;
   localparam logic [1:0] KIND_RELEASE = 2'd2;
   localparam logic [1:0] KIND_EMPTY   = 2'd3;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] item_id;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] item_id_res;
      logic        side;
      logic        last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_TURN
   } ctrl_state_type;

   typedef struct packed {
      logic enq;
      logic turn_start;
      logic pop;
      logic marker;
      logic flip;
   } cmd_type;

   typedef struct packed {
      logic s1_free;
      logic q_empty;
      logic limit_zero;
      logic burst_last;
   } sts_type;

endpackage

// File: src/drqba_ctrl.sv
`include "assert_macros.svh"

module drqba_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_func,
   input  drqba_pkg::sts_type sts,
   output drqba_pkg::cmd_type cmd
);
   import drqba_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = !sts.s1_free;
            if (req_valid && sts.s1_free) begin
               case (req_func)
                  FUNC_ENQ_N, FUNC_ENQ_S: begin
                     cmd.enq = 1'b1;
                  end
                  FUNC_TURN: begin
                     cmd.turn_start = 1'b1;
                     state_in       = ST_TURN;
                  end
                  default: ; // unused code: dropped
               endcase
            end
         end
         ST_TURN: begin
            if (sts.s1_free) begin
               if (!sts.q_empty && !sts.limit_zero) begin
                  cmd.pop = 1'b1;
                  if (sts.burst_last) begin
                     cmd.flip = 1'b1;
                     state_in = ST_IDLE;
                  end
               end else begin
                  // only reached before anything was released
                  cmd.marker = 1'b1;
                  cmd.flip   = 1'b1;
                  state_in   = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `DRQ_ASSERT_IMPLY(a_pop_not_empty, cmd.pop, !sts.q_empty, "pop issued on empty queue")
   `DRQ_ASSERT_IMPLY(a_flip_in_turn, cmd.flip, state_ff == ST_TURN, "direction flip outside a turn")
   `DRQ_ASSERT_NEXT(a_turn_enters, cmd.turn_start, state_ff == ST_TURN, "turn start did not enter turn")

endmodule

// File: src/drqba_dp.sv
`include "assert_macros.svh"

module drqba_dp #(
   parameter int QUEUE_DEPTH = drqba_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = drqba_pkg::ID_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  drqba_pkg::req_type req_data,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data,
   input  drqba_pkg::cmd_type cmd,
   output drqba_pkg::sts_type sts,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output drqba_pkg::rsp_type rsp_data
);
   import drqba_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [ID_WIDTH-1:0] north_mem [QUEUE_DEPTH];
   logic [ID_WIDTH-1:0] south_mem [QUEUE_DEPTH];

   logic [PTR_W-1:0] n_head_ff, n_head_in, n_tail_ff, n_tail_in;
   logic [PTR_W-1:0] s_head_ff, s_head_in, s_tail_ff, s_tail_in;
   logic [CNT_W-1:0] n_count_ff, n_count_in, s_count_ff, s_count_in;
   logic             serve_north_ff, serve_north_in;
   logic [6:0]       burst_limit_ff, burst_limit_in;
   logic [6:0]       burst_cnt_ff, burst_cnt_in;
   logic [ID_WIDTH-1:0] rd_data_ff;

   // result stage ahead of the output register
   logic       s1_valid_ff, s1_valid_in;
   logic [1:0] s1_kind_ff, s1_kind_in;
   logic       s1_side_ff, s1_side_in;
   logic       s1_last_ff, s1_last_in;
   logic       s1_mem_ff, s1_mem_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic                 out_free;
   logic                 enq_north;
   logic                 n_full, s_full, sel_full;
   logic [CNT_W-1:0]     sel_count;
   logic [6:0]           limit;
   logic                 n_push, s_push, n_pop, s_pop;
   logic [ID_WIDTH+15:0] wr_ext;
   logic [ID_WIDTH-1:0]  wr_id;
   logic [ID_WIDTH+15:0] rd_ext;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return p + 1'b1;
   endfunction

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign enq_north = (req_data.func == FUNC_ENQ_N);
   assign n_full    = (n_count_ff == CNT_W'(QUEUE_DEPTH));
   assign s_full    = (s_count_ff == CNT_W'(QUEUE_DEPTH));
   assign sel_full  = enq_north ? n_full : s_full;
   assign sel_count = serve_north_ff ? n_count_ff : s_count_ff;
   assign limit     = (burst_limit_ff > MAX_BURST) ? MAX_BURST : burst_limit_ff;

   assign n_push = cmd.enq && enq_north && !n_full;
   assign s_push = cmd.enq && !enq_north && !s_full;
   assign n_pop  = cmd.pop && serve_north_ff;
   assign s_pop  = cmd.pop && !serve_north_ff;

   assign wr_ext = {{ID_WIDTH{1'b0}}, req_data.item_id};
   assign wr_id  = wr_ext[ID_WIDTH-1:0];
   assign rd_ext = {16'd0, rd_data_ff};

   always_comb begin
      sts.s1_free    = !s1_valid_ff || out_free;
      sts.q_empty    = (sel_count == '0);
      sts.limit_zero = (limit == 7'd0);
      sts.burst_last = ((burst_cnt_ff + 7'd1) == limit) || (sel_count == CNT_W'(1));
   end

   always_comb begin
      n_head_in      = n_pop  ? ptr_next(n_head_ff) : n_head_ff;
      s_head_in      = s_pop  ? ptr_next(s_head_ff) : s_head_ff;
      n_tail_in      = n_push ? ptr_next(n_tail_ff) : n_tail_ff;
      s_tail_in      = s_push ? ptr_next(s_tail_ff) : s_tail_ff;
      n_count_in     = n_count_ff + CNT_W'(n_push) - CNT_W'(n_pop);
      s_count_in     = s_count_ff + CNT_W'(s_push) - CNT_W'(s_pop);
      serve_north_in = cmd.flip ? !serve_north_ff : serve_north_ff;
      burst_limit_in = csr_wr_en ? csr_wr_data : burst_limit_ff;
      burst_cnt_in   = cmd.turn_start ? 7'd0 :
                       (cmd.pop ? burst_cnt_ff + 7'd1 : burst_cnt_ff);
   end

   always_comb begin
      s1_valid_in = s1_valid_ff && !out_free;
      s1_kind_in  = s1_kind_ff;
      s1_side_in  = s1_side_ff;
      s1_last_in  = s1_last_ff;
      s1_mem_in   = s1_mem_ff;
      if (cmd.enq) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = sel_full ? KIND_REJECT : KIND_ACCEPT;
         s1_side_in  = enq_north;
         s1_last_in  = 1'b1;
         s1_mem_in   = 1'b0;
      end else if (cmd.pop) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = KIND_RELEASE;
         s1_side_in  = serve_north_ff;
         s1_last_in  = sts.burst_last;
         s1_mem_in   = 1'b1;
      end else if (cmd.marker) begin
         s1_valid_in = 1'b1;
         s1_kind_in  = KIND_EMPTY;
         s1_side_in  = serve_north_ff;
         s1_last_in  = 1'b1;
         s1_mem_in   = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in            = s1_valid_ff;
         rsp_data_in.kind        = s1_kind_ff;
         rsp_data_in.item_id_res = s1_mem_ff ? rd_ext[15:0] : 16'd0;
         rsp_data_in.side        = s1_side_ff;
         rsp_data_in.last        = s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_head_ff      <= '0;
         n_tail_ff      <= '0;
         n_count_ff     <= '0;
         s_head_ff      <= '0;
         s_tail_ff      <= '0;
         s_count_ff     <= '0;
         serve_north_ff <= 1'b1;
         burst_limit_ff <= BURST_RESET;
         burst_cnt_ff   <= '0;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         n_head_ff      <= n_head_in;
         n_tail_ff      <= n_tail_in;
         n_count_ff     <= n_count_in;
         s_head_ff      <= s_head_in;
         s_tail_ff      <= s_tail_in;
         s_count_ff     <= s_count_in;
         serve_north_ff <= serve_north_in;
         burst_limit_ff <= burst_limit_in;
         burst_cnt_ff   <= burst_cnt_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_kind_ff  <= s1_kind_in;
      s1_side_ff  <= s1_side_in;
      s1_last_ff  <= s1_last_in;
      s1_mem_ff   <= s1_mem_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (n_push) begin
         north_mem[n_tail_ff] <= wr_id;
      end
      if (s_push) begin
         south_mem[s_tail_ff] <= wr_id;
      end
   end

   // read data is held until the next pop, while the entry waits in the result stage
   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         rd_data_ff <= serve_north_ff ? north_mem[n_head_ff] : south_mem[s_head_ff];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `DRQ_ASSERT_IMPLY(a_load_when_free, cmd.enq || cmd.pop || cmd.marker, sts.s1_free, "result stage overwritten")
   `DRQ_ASSERT_NEXT(a_north_pop_count, n_pop, n_count_ff == $past(n_count_ff) - 1'b1, "north count not decremented")
   `DRQ_ASSERT(a_count_range, n_count_ff <= CNT_W'(QUEUE_DEPTH) && s_count_ff <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")

endmodule

// File: src/dual_ring_queue_burst_alternator_unit.sv
// Two ring FIFOs of item IDs (north, south) with alternating burst release. An enqueue
// request is answered by one result (accepted or rejected full). While the result stage
// is free, the idle unit takes one enqueue per cycle, and a turn request releases one
// queued ID per cycle from the served side, up to burst_limit (values above 64 act as
// 64), the final one marked last; a turn with nothing to release gives a single empty
// marker. Each FIFO memory has one registered read port. The direction flips after every
// turn, north first after reset. Results pass through a holding stage and an output
// register, so a new request is taken while a finished result still waits. burst_limit is
// to be written by the user only while the unit is idle; the unit does not enforce this.
module dual_ring_queue_burst_alternator_unit #(
   parameter int QUEUE_DEPTH = drqba_pkg::QUEUE_DEPTH_DEF,
   parameter int ID_WIDTH    = drqba_pkg::ID_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  drqba_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output drqba_pkg::rsp_type rsp_data,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data
);
   import drqba_pkg::*;

   cmd_type cmd;
   sts_type sts;

   drqba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_func  (req_data.func),
      .sts       (sts),
      .cmd       (cmd)
   );

   drqba_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

// File: tb/sv/tb_dual_ring_queue_burst_alternator_unit.sv
`timescale 1ns / 100ps

module tb_dual_ring_queue_burst_alternator_unit;
   import drqba_pkg::*;

   localparam logic [1:0] FUNC_SPARE  = 2'd3;
   localparam int         SETTLE      = 12;
   localparam int         CYCLE_LIMIT = 200000;
   localparam int         IDLE_PCT    = 36;

   typedef struct {
      bit          is_cfg;
      logic [6:0]  cfg_value;
      req_type     req;
      int          reps;
      bit          typed;
      rsp_type     want;
   } plan_row_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   rsp_type    rsp_data;
   logic       csr_wr_en;
   logic [6:0] csr_wr_data;

   bit         quiet = 1'b0;
   int         errors = 0;
   int         cycles = 0;

   // predictor state, indexed by side: 1 north, 0 south
   logic [15:0] ring_ids [2][QUEUE_DEPTH_DEF];
   logic [3:0]  ring_head [2];
   logic [3:0]  ring_tail [2];
   logic [4:0]  ring_count [2];
   logic        serve_north;
   logic [6:0]  burst_limit;

   rsp_type      expected_rsps [$];
   plan_row_type plan [$];

   dual_ring_queue_burst_alternator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic flag_mismatch(input string what, input int got, input int want);
      $display("%0t mismatch: %s got %0h expected %0h", $time, what, got, want);
      errors++;
   endtask

   // Works out the results of one accepted request and queues them.
   // Typed rows supply their own result for an enqueue or an empty marker; state is still advanced here.
   task automatic predict_request(input req_type r, input bit typed, input rsp_type want);
      rsp_type res;
      logic    sd;
      int      limit;
      int      n;
      res = '0;
      case (r.func)
         FUNC_ENQ_N, FUNC_ENQ_S: begin
            sd = (r.func == FUNC_ENQ_N);
            res.side = sd;
            res.last = 1'b1;
            if (ring_count[sd] == QUEUE_DEPTH_DEF) begin
               res.kind = KIND_REJECT;
            end else begin
               ring_ids[sd][ring_tail[sd]] = r.item_id;
               ring_tail[sd]++;
               ring_count[sd]++;
               res.kind = KIND_ACCEPT;
            end
            expected_rsps.push_back(typed ? want : res);
         end
         FUNC_TURN: begin
            sd = serve_north;
            limit = (burst_limit > MAX_BURST) ? int'(MAX_BURST) : int'(burst_limit);
            n = 0;
            while (n < limit && ring_count[sd] != 0) begin
               res.kind = KIND_RELEASE;
               res.item_id_res = ring_ids[sd][ring_head[sd]];
               res.side = sd;
               ring_head[sd]++;
               ring_count[sd]--;
               n++;
               res.last = (n == limit) || (ring_count[sd] == 0);
               expected_rsps.push_back(res);
            end
            if (n == 0) begin
               res.kind = KIND_EMPTY;
               res.item_id_res = '0;
               res.side = sd;
               res.last = 1'b1;
               expected_rsps.push_back(typed ? want : res);
            end
            serve_north = ~serve_north;
         end
         default: ; // spare selector: ignored
      endcase
   endtask

   task automatic send_request(input req_type r, input bit typed, input rsp_type want);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = r;
      do @(posedge clock); while (req_stall);
      predict_request(r, typed, want);
   endtask

   // Waits for every expected result, then lets any ignored request drain.
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsps.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_burst(input logic [6:0] value);
      drain();
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      burst_limit = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic add_row(input bit is_cfg, input logic [6:0] cfg, input logic [1:0] f,
                          input logic [15:0] id, input int reps, input bit typed,
                          input logic [1:0] k, input logic s);
      plan_row_type row;
      row.is_cfg           = is_cfg;
      row.cfg_value        = cfg;
      row.req.func         = f;
      row.req.item_id      = id;
      row.reps             = reps;
      row.typed            = typed;
      row.want.kind        = k;
      row.want.item_id_res = '0;
      row.want.side        = s;
      row.want.last        = 1'b1;
      plan.push_back(row);
   endtask

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
   end

   always @(posedge clock) begin : rsp_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            flag_mismatch("result with none pending, kind", rsp_data.kind, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_data.kind != want.kind)
               flag_mismatch("kind", rsp_data.kind, want.kind);
            if (rsp_data.item_id_res != want.item_id_res)
               flag_mismatch("item_id_res", rsp_data.item_id_res, want.item_id_res);
            if (rsp_data.side != want.side)
               flag_mismatch("side", rsp_data.side, want.side);
            if (rsp_data.last != want.last)
               flag_mismatch("last", rsp_data.last, want.last);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout, %0d results still pending", $time, expected_rsps.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      req_type    r;
      rsp_type    none;
      logic [6:0] phase_cfg [6];
      int         phase_len [6];
      int         count;
      int         total;
      int         pick;

      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_wr_en   = 1'b0;
      csr_wr_data = '0;
      none        = '0;

      for (int s = 0; s < 2; s++) begin
         ring_head[s]  = '0;
         ring_tail[s]  = '0;
         ring_count[s] = '0;
      end
      serve_north = 1'b1;
      burst_limit = BURST_RESET;

      // directed part; direction starts north after reset
      add_row(0, 0, FUNC_TURN, 16'h0000, 1, 1, KIND_EMPTY, 1'b1);
      add_row(0, 0, FUNC_ENQ_N, 16'hFFFF, 1, 1, KIND_ACCEPT, 1'b1);
      add_row(0, 0, FUNC_ENQ_N, 16'h0000, 1, 1, KIND_ACCEPT, 1'b1);
      add_row(0, 0, FUNC_SPARE, 16'h1234, 1, 0, KIND_ACCEPT, 1'b0);
      add_row(0, 0, FUNC_ENQ_S, 16'h8000, 16, 1, KIND_ACCEPT, 1'b0);
      add_row(0, 0, FUNC_ENQ_S, 16'h7FFF, 1, 1, KIND_REJECT, 1'b0);
      add_row(0, 0, FUNC_TURN, 16'h0000, 1, 0, KIND_ACCEPT, 1'b0);
      add_row(0, 0, FUNC_TURN, 16'hFFFF, 1, 0, KIND_ACCEPT, 1'b0);
      // zero burst: empty marker although south still holds requests
      add_row(1, 7'd0, FUNC_TURN, 16'h0000, 0, 0, KIND_ACCEPT, 1'b0);
      add_row(0, 0, FUNC_TURN, 16'h0000, 1, 1, KIND_EMPTY, 1'b0);
      add_row(1, 7'd127, FUNC_TURN, 16'h0000, 0, 0, KIND_ACCEPT, 1'b0);
      add_row(0, 0, FUNC_TURN, 16'h0000, 1, 1, KIND_EMPTY, 1'b1);
      add_row(0, 0, FUNC_TURN, 16'h0000, 1, 0, KIND_ACCEPT, 1'b0);

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (plan[i]) begin
         if (plan[i].is_cfg) begin
            write_burst(plan[i].cfg_value);
         end else begin
            for (int k = 0; k < plan[i].reps; k++) begin
               r = plan[i].req;
               r.item_id = plan[i].req.item_id + 16'(k);
               send_request(r, plan[i].typed, plan[i].want);
            end
         end
      end

      // random part, a burst setting per phase
      phase_cfg = '{7'd1, 7'd64, 7'($urandom_range(2, 16)), 7'd0, 7'd127,
                    7'($urandom_range(1, 127))};
      phase_len = '{35, 35, 35, 10, 40, 40};
      total = 0;
      for (int p = 0; p < 6; p++) begin
         write_burst(phase_cfg[p]);
         count = 0;
         while (count < phase_len[p]) begin
            pick = $urandom_range(0, 99);
            if (pick < 5)       r.func = FUNC_SPARE;
            else if (pick < 38) r.func = FUNC_ENQ_N;
            else if (pick < 71) r.func = FUNC_ENQ_S;
            else                r.func = FUNC_TURN;
            case ($urandom_range(0, 7))
               0:       r.item_id = 16'h0000;
               1:       r.item_id = 16'hFFFF;
               default: r.item_id = 16'($urandom_range(0, 65535));
            endcase
            if (r.func != FUNC_SPARE) begin
               count++;
               total++;
            end
            quiet = (total >= 100) && (total < 150);
            send_request(r, 1'b0, none);
         end
      end
      quiet = 1'b0;

      drain();
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+src
src/drqba_pkg.sv
src/drqba_ctrl.sv
src/drqba_dp.sv
src/dual_ring_queue_burst_alternator_unit.sv
tb/sv/tb_dual_ring_queue_burst_alternator_unit.sv
